[hw/rtl/cdrbd_pkg.sv]
// Shared constants, types and controller/datapath structs for the digit RAM device.
`timescale 1ns / 1ps

package cdrbd_pkg;

    localparam int WORDS   = 64;
    localparam int DIGITS  = 16;
    localparam int DIGIT_W = 4;
    localparam int WORD_W  = DIGITS * DIGIT_W;
    localparam int IDX_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int STATE_W = 4;
    localparam int INSTR_W = 16;
    localparam int PAGE_W  = 2;
    localparam int ADDR_W  = 2 * DIGIT_W;
    // wide enough for base_page*WORDS + WORDS
    localparam int SPAN_W  = PAGE_W + $clog2(WORDS + 1) + 1;

    localparam logic [INSTR_W-1:0] INSTR_STORE  = 16'h0A76;
    localparam logic [INSTR_W-1:0] INSTR_RECALL = 16'h0A86;
    localparam int                 KIND_BIT     = 7;

    localparam logic [STATE_W-1:0] BUS_STATE_FIRST = 4'd0;
    localparam logic [STATE_W-1:0] BUS_STATE_LAST  = 4'd15;

    localparam logic [DIGIT_W-1:0] ERASED_DIGIT = 4'hE;
    localparam logic [WORD_W-1:0]  ERASED_WORD  = {DIGITS{ERASED_DIGIT}};

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SPAN_W-1:0] t_span;

    typedef struct packed {
        logic upd;          // an input item is accepted this cycle
        logic load_direct;  // load a non-driving result
        logic load_read;    // load the recalled word from the RAM
    } t_dp_cmd;

    typedef struct packed {
        logic recall_drive; // current input item drives a recalled word
    } t_dp_sts;

endpackage

[hw/rtl/cdrbd_if.sv]
// Channel interfaces: bus event input, result output and configuration write.
`timescale 1ns / 1ps

interface cdrbd_in_if;
    logic                           valid;
    logic                           ready;
    logic [cdrbd_pkg::STATE_W-1:0]  bus_state;
    logic                           bus_write;
    logic [cdrbd_pkg::INSTR_W-1:0]  instr_word;
    logic [cdrbd_pkg::WORD_W-1:0]   io_digits;

    modport source (output valid, bus_state, bus_write, instr_word, io_digits, input ready);
    modport sink   (input valid, bus_state, bus_write, instr_word, io_digits, output ready);
endinterface

interface cdrbd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           drive_valid;
    logic [cdrbd_pkg::WORD_W-1:0]   read_word;

    modport source (output valid, drive_valid, read_word, input ready);
    modport sink   (input valid, drive_valid, read_word, output ready);
endinterface

interface cdrbd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cdrbd_pkg::PAGE_W-1:0]   base_page;

    modport source (output valid, base_page, input ready);
    modport sink   (input valid, base_page, output ready);
endinterface

[hw/rtl/cdrbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cdrbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/cdrbd_ctrl.sv]
// Controller: handshake, recall read sequencing and output valid.
`timescale 1ns / 1ps

module cdrbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  cdrbd_pkg::t_dp_sts i_sts,
    output cdrbd_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_RUN) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (accept && i_sts.recall_drive) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_comb begin
        o_cmd.upd         = accept;
        o_cmd.load_direct = accept && !i_sts.recall_drive;
        o_cmd.load_read   = (r_state == ST_READ);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_direct || o_cmd.load_read) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/cdrbd_dp.sv]
// Datapath: command state, address decode, word RAM with written flags, result register.
`timescale 1ns / 1ps

module cdrbd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cdrbd_pkg::PAGE_W-1:0]        i_cfg_base_page,
    input  logic [cdrbd_pkg::STATE_W-1:0]       i_bus_state,
    input  logic                                i_bus_write,
    input  logic [cdrbd_pkg::INSTR_W-1:0]       i_instr_word,
    input  logic [cdrbd_pkg::WORD_W-1:0]        i_io_digits,
    input  cdrbd_pkg::t_dp_cmd                  i_cmd,
    output cdrbd_pkg::t_dp_sts                  o_sts,
    output logic                                o_drive_valid,
    output logic [cdrbd_pkg::WORD_W-1:0]        o_read_word
);

    logic [cdrbd_pkg::PAGE_W-1:0] r_base_page;
    logic                         r_wait, n_wait;
    logic                         r_exec, n_exec;
    logic                         r_is_store, n_is_store;
    cdrbd_pkg::t_idx              r_idx, n_idx;
    logic [cdrbd_pkg::WORDS-1:0]  r_written;
    logic                         r_drive;
    logic [cdrbd_pkg::WORD_W-1:0] r_word;

    logic                         ev_read, ev_tick, store_now, decode, in_page;
    cdrbd_pkg::t_span             addr, start, stop;
    logic [cdrbd_pkg::WORD_W-1:0] ram_rdata;

    assign ev_read = (i_bus_state == cdrbd_pkg::BUS_STATE_FIRST) && i_bus_write;
    assign ev_tick = (i_bus_state == cdrbd_pkg::BUS_STATE_LAST) && !i_bus_write;

    assign o_sts.recall_drive = ev_read && r_exec && !r_is_store;

    assign store_now = i_cmd.upd && ev_tick && r_exec && r_is_store;
    assign decode    = (i_instr_word == cdrbd_pkg::INSTR_STORE)
                    || (i_instr_word == cdrbd_pkg::INSTR_RECALL);

    // address is digit1*16 + digit0
    assign addr    = cdrbd_pkg::t_span'(i_io_digits[cdrbd_pkg::ADDR_W-1:0]);
    assign start   = cdrbd_pkg::t_span'(r_base_page) * cdrbd_pkg::t_span'(cdrbd_pkg::WORDS);
    assign stop    = start + cdrbd_pkg::t_span'(cdrbd_pkg::WORDS);
    assign in_page = (addr >= start) && (addr < stop);

    always_comb begin
        n_wait     = r_wait;
        n_exec     = r_exec;
        n_is_store = r_is_store;
        n_idx      = r_idx;
        if (i_cmd.upd) begin
            if (o_sts.recall_drive) begin
                n_exec = 1'b0;
            end
            if (ev_tick) begin
                if (store_now) begin
                    n_exec = 1'b0;
                end
                if (r_wait) begin
                    n_wait = 1'b0;
                    n_exec = 1'b1;
                end
                if (decode && in_page) begin
                    n_idx      = cdrbd_pkg::t_idx'(addr - start);
                    n_is_store = !i_instr_word[cdrbd_pkg::KIND_BIT];
                    n_wait     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_page <= '0;
            r_wait      <= 1'b0;
            r_exec      <= 1'b0;
            r_is_store  <= 1'b0;
            r_idx       <= '0;
            r_written   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base_page <= i_cfg_base_page;
            end
            r_wait     <= n_wait;
            r_exec     <= n_exec;
            r_is_store <= n_is_store;
            r_idx      <= n_idx;
            if (store_now) begin
                r_written[r_idx] <= 1'b1;
            end
        end
    end

    cdrbd_ram #(
        .WIDTH (cdrbd_pkg::WORD_W),
        .DEPTH (cdrbd_pkg::WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (store_now),
        .i_waddr (r_idx),
        .i_wdata (i_io_digits),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            r_drive <= 1'b0;
            r_word  <= '0;
        end else if (i_cmd.load_read) begin
            r_drive <= 1'b1;
            r_word  <= r_written[r_idx] ? ram_rdata : cdrbd_pkg::ERASED_WORD;
        end
    end

    assign o_drive_valid = r_drive;
    assign o_read_word   = r_word;

endmodule

[hw/rtl/calculator_digit_ram_bus_device.sv]
// Top level of the digit-bus RAM device: controller, datapath and channel wiring.
//
//  channel  | dir | payload                                        | item
//  ---------+-----+------------------------------------------------+--------------------
//  i_in     | in  | bus_state[3:0] bus_write instr_word[15:0]      | one bus state event
//           |     | io_digits[63:0]                                |
//  o_out    | out | drive_valid read_word[63:0]                    | one result per event
//  i_cfg    | in  | base_page[1:0]                                 | register write
//
//  Other events load the result register directly; an event that drives a recalled
//  word first passes through a read state for the registered RAM read port.
//  Reset clears control state; words never stored read as all 0xE digits through
//  per-word written flags, so no clearing pass is needed.
//  i_in waits while the result register holds an item that o_out has not taken.
//  i_cfg is always ready.
`timescale 1ns / 1ps

module calculator_digit_ram_bus_device (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdrbd_in_if.sink    i_in,
    cdrbd_out_if.source o_out,
    cdrbd_cfg_if.sink   i_cfg
);

    cdrbd_pkg::t_dp_cmd cmd;
    cdrbd_pkg::t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    cdrbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cdrbd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid && i_cfg.ready),
        .i_cfg_base_page (i_cfg.base_page),
        .i_bus_state     (i_in.bus_state),
        .i_bus_write     (i_in.bus_write),
        .i_instr_word    (i_in.instr_word),
        .i_io_digits     (i_in.io_digits),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_drive_valid   (o_out.drive_valid),
        .o_read_word     (o_out.read_word)
    );

endmodule

[hw/rtl/cdrbd_checker.sv]
// Port-level assertions for the digit-bus RAM device, bound to the top level.
`timescale 1ns / 1ps

module cdrbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic [cdrbd_pkg::STATE_W-1:0]  i_in_bus_state,
    input logic                           i_in_bus_write,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_drive_valid,
    input logic [cdrbd_pkg::WORD_W-1:0]   i_out_read_word
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_word)
            && $stable(i_out_drive_valid))
        else $error("result item changed while stalled");

    a_no_drive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_drive_valid |-> i_out_read_word == '0)
        else $error("non-driving result carries data");

    a_plain_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !(i_in_bus_state == cdrbd_pkg::BUS_STATE_FIRST && i_in_bus_write)
            |=> i_out_valid && !i_out_drive_valid)
        else $error("non-read event did not give a plain result next cycle");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while result register is blocked");

endmodule

bind calculator_digit_ram_bus_device cdrbd_checker u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_bus_state    (i_in.bus_state),
    .i_in_bus_write    (i_in.bus_write),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_drive_valid (o_out.drive_valid),
    .i_out_read_word   (o_out.read_word)
);
